@@ rtl/core/hme_pkg.sv @@
package hme_pkg;

  localparam int unsigned CNT_W      = 21;
  localparam int unsigned LVL_W      = 9;
  localparam int unsigned BINS       = 256;
  localparam int unsigned ADDR_W     = 8;
  localparam int unsigned PIXELS_MAX = 1048576;

  typedef enum logic [2:0] {
    CMD_COUNT_SRC = 3'd0,
    CMD_COUNT_TGT = 3'd1,
    CMD_BUILD     = 3'd2,
    CMD_MAP       = 3'd3,
    CMD_CLEAR     = 3'd4
  } cmd_t;

  localparam logic KIND_MAP   = 1'b0;
  localparam logic KIND_BUILD = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] pixel_value;
  } item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] mapped_value;
    logic       status;
  } result_t;

endpackage

@@ rtl/core/hme_stream_if.sv @@
interface hme_stream_if #(
  parameter int unsigned W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/hme_front.sv @@
module hme_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hme_pkg::item_t       in_item,
  output logic                 q_valid,
  input  logic                 q_ready,
  output hme_pkg::item_t       q_item
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = 2;

  hme_pkg::item_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [PTR_W:0]   cnt_r;
  logic             push, pop, legal;

  always_comb begin
    legal = (in_item.command == hme_pkg::CMD_COUNT_SRC) ||
            (in_item.command == hme_pkg::CMD_COUNT_TGT) ||
            (in_item.command == hme_pkg::CMD_BUILD) ||
            (in_item.command == hme_pkg::CMD_MAP) ||
            (in_item.command == hme_pkg::CMD_CLEAR);
  end

  assign in_ready = (cnt_r != (PTR_W+1)'(DEPTH));
  assign push     = in_valid && in_ready && legal;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_valid && q_ready;
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

@@ rtl/core/hme_back.sv @@
module hme_back #(
  parameter int unsigned VALUE_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [hme_pkg::LVL_W-1:0] level_count,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  hme_pkg::item_t        q_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hme_pkg::result_t      out_res
);

  localparam int unsigned SPACE = (VALUE_BITS >= 8) ? 256 : (1 << VALUE_BITS);
  localparam int unsigned CW    = hme_pkg::CNT_W;
  localparam int unsigned PW    = 2 * CW;
  localparam int unsigned AW    = hme_pkg::ADDR_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CNT_RD = 9'b000000010,
    S_CNT_WR = 9'b000000100,
    S_MAP_RD = 9'b000001000,
    S_CLR    = 9'b000010000,
    S_B_RD   = 9'b000100000,
    S_B_CMP  = 9'b001000000,
    S_B_MUL  = 9'b010000000,
    S_FILL   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0] src_mem [hme_pkg::BINS];
  logic [CW-1:0] tgt_mem [hme_pkg::BINS];
  logic [7:0]    tab_mem [hme_pkg::BINS];

  logic [CW-1:0] src_tot_r, tgt_tot_r;
  logic          tvalid_r;
  logic          is_tgt_r;
  logic [AW-1:0] px_r;
  logic [CW-1:0] src_rd_r, tgt_rd_r;
  logic [7:0]    tab_rd_r;
  logic [AW-1:0] i_r, j_r;
  logic [CW-1:0] cs_r, ct_r;
  logic [PW-1:0] lhs_r, rhs_r;
  logic          ov_r;
  hme_pkg::result_t res_r;
  logic [AW-1:0] last_r;
  logic [CW-1:0] tgt_mem_next;

  logic [8:0]    lvl;
  logic [AW-1:0] lmax;
  logic [AW-1:0] clamp_px;
  logic [AW-1:0] src_addr, tgt_addr;

  always_comb begin
    lvl = level_count;
    if (lvl < 9'd2) lvl = 9'd2;
    if (lvl > 9'(SPACE)) lvl = 9'(SPACE);
    lmax = AW'(lvl - 9'd1);
    clamp_px = (q_item.pixel_value > lmax) ? lmax : q_item.pixel_value;
  end

  always_comb begin
    if (state_r == S_IDLE) begin
      src_addr = (q_item.command == hme_pkg::CMD_BUILD) ? '0 : q_item.pixel_value;
      tgt_addr = src_addr;
    end else if (state_r == S_CNT_RD) begin
      src_addr = px_r;
      tgt_addr = px_r;
    end else if (state_r == S_B_CMP) begin
      src_addr = i_r + 1'b1;
      tgt_addr = j_r;
    end else begin
      src_addr = i_r;
      tgt_addr = j_r;
    end
  end

  assign q_ready   = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_res   = res_r;

  logic take;
  assign take = q_valid && q_ready;

  logic [CW-1:0] tot_sel;
  assign tot_sel = is_tgt_r ? tgt_tot_r : src_tot_r;

  logic j_adv;
  assign j_adv = ({1'b0, j_r} + 9'd1 < lvl) && (lhs_r < rhs_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          unique case (q_item.command)
            hme_pkg::CMD_COUNT_SRC, hme_pkg::CMD_COUNT_TGT: begin
              state_nxt = ({1'b0, q_item.pixel_value} < lvl) ? S_CNT_RD : S_IDLE;
            end
            hme_pkg::CMD_BUILD: begin
              state_nxt = (src_tot_r == '0 || tgt_tot_r == '0) ? S_IDLE : S_B_RD;
            end
            hme_pkg::CMD_MAP: state_nxt = tvalid_r ? S_MAP_RD : S_IDLE;
            hme_pkg::CMD_CLEAR: state_nxt = S_CLR;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CNT_RD: state_nxt = S_CNT_WR;
      S_CNT_WR: state_nxt = S_IDLE;
      S_MAP_RD: state_nxt = S_IDLE;
      S_CLR:    state_nxt = (px_r == 8'hFF) ? S_IDLE : S_CLR;
      S_B_RD:   state_nxt = S_B_MUL;
      S_B_MUL:  state_nxt = S_B_CMP;
      S_B_CMP: begin
        if (j_adv) state_nxt = S_B_MUL;
        else if ({1'b0, i_r} == 9'(lvl - 9'd1)) state_nxt = (lvl == 9'd256) ? S_IDLE : S_FILL;
        else state_nxt = S_B_RD;
      end
      S_FILL: state_nxt = (i_r == 8'hFF) ? S_IDLE : S_FILL;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    src_rd_r <= src_mem[src_addr];
    tgt_rd_r <= tgt_mem[tgt_addr];
    tab_rd_r <= tab_mem[clamp_px];
    if (state_r == S_CNT_WR && tot_sel < CW'(hme_pkg::PIXELS_MAX)) begin
      if (is_tgt_r) tgt_mem[px_r] <= tgt_rd_r + 1'b1;
      else src_mem[px_r] <= src_rd_r + 1'b1;
    end
    if (state_r == S_CLR) begin
      src_mem[px_r] <= '0;
      tgt_mem[px_r] <= '0;
    end
    if (state_r == S_B_CMP && !j_adv) tab_mem[i_r] <= j_r;
    if (state_r == S_FILL) tab_mem[i_r] <= last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      px_r      <= '0;
      src_tot_r <= '0;
      tgt_tot_r <= '0;
      tvalid_r  <= 1'b0;
      ov_r      <= 1'b0;
      res_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            is_tgt_r <= (q_item.command == hme_pkg::CMD_COUNT_TGT);
            px_r     <= (q_item.command == hme_pkg::CMD_CLEAR) ? '0 : q_item.pixel_value;
            i_r      <= '0;
            j_r      <= '0;
            cs_r     <= '0;
            ct_r     <= '0;
            unique case (q_item.command)
              hme_pkg::CMD_BUILD: begin
                if (src_tot_r == '0 || tgt_tot_r == '0) begin
                  tvalid_r <= 1'b0;
                  ov_r     <= 1'b1;
                  res_r    <= '{hme_pkg::KIND_BUILD, 8'd0, hme_pkg::STATUS_BAD};
                end
              end
              hme_pkg::CMD_MAP: begin
                if (!tvalid_r) begin
                  ov_r  <= 1'b1;
                  res_r <= '{hme_pkg::KIND_MAP, 8'd0, hme_pkg::STATUS_BAD};
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_CNT_WR: begin
          if (tot_sel < CW'(hme_pkg::PIXELS_MAX)) begin
            if (is_tgt_r) tgt_tot_r <= tgt_tot_r + 1'b1;
            else src_tot_r <= src_tot_r + 1'b1;
          end
        end
        S_MAP_RD: begin
          ov_r  <= 1'b1;
          res_r <= '{hme_pkg::KIND_MAP, tab_rd_r, hme_pkg::STATUS_OK};
        end
        S_CLR: begin
          px_r      <= px_r + 1'b1;
          src_tot_r <= '0;
          tgt_tot_r <= '0;
          tvalid_r  <= 1'b0;
        end
        S_B_RD: begin
          cs_r <= cs_r + src_rd_r;
          if (i_r == '0) ct_r <= tgt_rd_r;
        end
        S_B_MUL: begin
          lhs_r <= PW'(ct_r) * PW'(src_tot_r);
          rhs_r <= PW'(cs_r) * PW'(tgt_tot_r);
        end
        S_B_CMP: begin
          if (j_adv) begin
            j_r <= j_r + 1'b1;
            ct_r <= ct_r + tgt_mem_next;
          end else begin
            last_r <= j_r;
            if ({1'b0, i_r} == 9'(lvl - 9'd1)) begin
              tvalid_r <= 1'b1;
              i_r      <= i_r + 1'b1;
              if (lvl == 9'd256) begin
                ov_r  <= 1'b1;
                res_r <= '{hme_pkg::KIND_BUILD, 8'd0, hme_pkg::STATUS_OK};
              end
            end else begin
              i_r <= i_r + 1'b1;
            end
          end
        end
        S_FILL: begin
          i_r <= i_r + 1'b1;
          if (i_r == 8'hFF) begin
            ov_r  <= 1'b1;
            res_r <= '{hme_pkg::KIND_BUILD, 8'd0, hme_pkg::STATUS_OK};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tgt_mem_next <= tgt_mem[j_r + 1'b1];
  end

endmodule

@@ rtl/core/histogram_matching_engine.sv @@
// Histogram matching engine.
// Input channel in_ch: each item carries a command and a pixel_value. A four-entry
// queue takes items while the back end works and stalls in_ch only when it is full.
// An item is registered in the queue before the back end sees it. In the back end a
// count item passes a read and a write state, a clear item steps through every bin,
// and a map item reads the table before its result is registered, or registers its
// result when it is taken if no valid table exists. A build passes a read, a multiply and a
// compare state per level in use, repeating multiply and compare per target level step,
// then fills each bin above the last level. Items are carried out one at a time.
// Result channel out_ch: one result per build or map item, held in an output register
// until out_ready; the back end takes no new item while that register is full, and
// the queue then fills and stalls the input.
// Configuration: APB-style write of level_count at address 0; pready is always high.
// Reset (synchronous, rst_n low) empties the queue, clears the totals and the valid
// table flag and sets level_count to 256; a clear pass then zeroes every bin, and items
// taken during that pass wait in the queue.
// The table build uses one multiplier pair per comparison step.
module histogram_matching_engine #(
  parameter int unsigned VALUE_BITS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  hme_stream_if.sink    in_ch,
  hme_stream_if.source  out_ch,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [1:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  localparam logic [1:0] REG_LEVEL_COUNT = 2'd0;

  logic [hme_pkg::LVL_W-1:0] lc_r;
  logic                      q_valid, q_ready;
  hme_pkg::item_t            q_item, in_item;
  hme_pkg::result_t          res;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_LEVEL_COUNT) ? {23'd0, lc_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r <= 9'd256;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_LEVEL_COUNT) begin
      lc_r <= cfg_pwdata[8:0];
    end
  end

  assign in_item = in_ch.data;

  hme_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  hme_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .level_count (lc_r),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_res     (res)
  );

  assign out_ch.data = res;

`ifndef ASSERT_OFF
  a_map_zero_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && res.status == hme_pkg::STATUS_BAD |-> res.mapped_value == 8'd0)
    else $error("invalid table result has nonzero level");
  a_build_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && res.result_kind == hme_pkg::KIND_BUILD |-> res.mapped_value == 8'd0)
    else $error("build result has nonzero level");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res))
    else $error("result dropped while stalled");
`endif

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int unsigned SETTLE_CYCLES  = 3000;

  logic clk = 1'b0;
  logic rst_n;

  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  localparam logic [1:0] ADDR_LEVEL_COUNT = 2'd0;

  hme_stream_if #(.W($bits(hme_pkg::item_t)))   in_ch ();
  hme_stream_if #(.W($bits(hme_pkg::result_t))) out_ch ();

  histogram_matching_engine u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  class level_map_tracker;
    int unsigned level_reg;
    int unsigned src_bins[256];
    int unsigned tgt_bins[256];
    int unsigned src_total;
    int unsigned tgt_total;
    logic [7:0]  match_lut[256];
    bit          lut_valid;
    hme_pkg::result_t pending_results[$];
    int unsigned mismatches;

    function new();
      level_reg = 256;
      lut_valid = 1'b0;
      mismatches = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (src_bins[i]) begin
        src_bins[i] = 0;
        tgt_bins[i] = 0;
      end
      src_total = 0;
      tgt_total = 0;
      lut_valid = 1'b0;
    endfunction

    function int unsigned levels();
      if (level_reg < 2) return 2;
      if (level_reg > 256) return 256;
      return level_reg;
    endfunction

    function logic build_lut();
      longint unsigned ns, nt, cs, ct;
      int unsigned l, j;
      l = levels();
      ns = 64'(src_total);
      nt = 64'(tgt_total);
      if (ns == 0 || nt == 0) begin
        lut_valid = 1'b0;
        return hme_pkg::STATUS_BAD;
      end
      j = 0;
      cs = 0;
      ct = 64'(tgt_bins[0]);
      for (int unsigned i = 0; i < l; i++) begin
        cs += 64'(src_bins[i]);
        while (j + 1 < l && ct * ns < cs * nt) begin
          j++;
          ct += 64'(tgt_bins[j]);
        end
        match_lut[i] = j[7:0];
      end
      for (int unsigned i = l; i < 256; i++) match_lut[i] = match_lut[l-1];
      lut_valid = 1'b1;
      return hme_pkg::STATUS_OK;
    endfunction

    function void note_item(hme_pkg::item_t it);
      hme_pkg::result_t r;
      int unsigned px;
      px = 32'(it.pixel_value);
      case (it.command)
        hme_pkg::CMD_COUNT_SRC: if (px < levels() && src_total < hme_pkg::PIXELS_MAX) begin
          src_bins[px]++;
          src_total++;
        end
        hme_pkg::CMD_COUNT_TGT: if (px < levels() && tgt_total < hme_pkg::PIXELS_MAX) begin
          tgt_bins[px]++;
          tgt_total++;
        end
        hme_pkg::CMD_BUILD: begin
          r.result_kind = hme_pkg::KIND_BUILD;
          r.mapped_value = 8'd0;
          r.status = build_lut();
          pending_results = {pending_results, r};
        end
        hme_pkg::CMD_MAP: begin
          r.result_kind = hme_pkg::KIND_MAP;
          if (!lut_valid) begin
            r.mapped_value = 8'd0;
            r.status = hme_pkg::STATUS_BAD;
          end else begin
            if (px > levels() - 1) px = levels() - 1;
            r.mapped_value = match_lut[px];
            r.status = hme_pkg::STATUS_OK;
          end
          pending_results = {pending_results, r};
        end
        hme_pkg::CMD_CLEAR: wipe();
        default: ;
      endcase
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      mismatches++;
    endtask

    task check_result(hme_pkg::result_t r);
      hme_pkg::result_t e;
      if (pending_results.size() == 0) begin
        report("unexpected result", 32'(r), 0);
      end else begin
        e = pending_results.pop_front();
        if (r.result_kind !== e.result_kind)
          report("result_kind", 32'(r.result_kind), 32'(e.result_kind));
        if (r.mapped_value !== e.mapped_value)
          report("mapped_value", 32'(r.mapped_value), 32'(e.mapped_value));
        if (r.status !== e.status) report("status", 32'(r.status), 32'(e.status));
      end
    endtask
  endclass

  level_map_tracker tracker = new();
  bit idle_on = 1'b1;
  int unsigned sink_stall = 0;
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (sink_stall > 0) begin
      out_ch.ready <= 1'b0;
      sink_stall--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      sink_stall = $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_result(hme_pkg::result_t'(out_ch.data));
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable) || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task send_item(logic [2:0] cmd, logic [7:0] px);
    hme_pkg::item_t it;
    it.command = cmd;
    it.pixel_value = px;
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_item(it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task settle();
    in_ch.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_level_count(int unsigned v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_LEVEL_COUNT;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    tracker.level_reg = v & 32'h1FF;
  endtask

  function logic [7:0] pick_pixel(int unsigned lo, int unsigned hi);
    if ($urandom_range(0, 6) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(lo, hi));
  endfunction

  task run_phase(int unsigned lvl_raw, int unsigned budget);
    int unsigned sent, l, lo, hi, k;
    bit skip_src, skip_tgt;
    settle();
    write_level_count(lvl_raw);
    l = tracker.levels();
    send_item(hme_pkg::CMD_CLEAR, 8'd0);
    sent = 1;
    while (sent < budget) begin
      lo = $urandom_range(0, l - 1);
      hi = $urandom_range(lo, l - 1);
      skip_src = ($urandom_range(0, 11) == 0);
      skip_tgt = ($urandom_range(0, 11) == 0);
      k = $urandom_range(10, 60);
      repeat (k) begin
        if ($urandom_range(0, 1) == 0) begin
          if (!skip_src) send_item(hme_pkg::CMD_COUNT_SRC, pick_pixel(0, l - 1));
        end else if (!skip_tgt) begin
          send_item(hme_pkg::CMD_COUNT_TGT, pick_pixel(lo, hi));
        end
        sent++;
      end
      send_item(hme_pkg::CMD_BUILD, 8'd0);
      k = $urandom_range(8, 40);
      repeat (k) begin
        case ($urandom_range(0, 19))
          0: send_item(hme_pkg::CMD_COUNT_SRC, pick_pixel(0, l - 1));
          1: send_item(hme_pkg::CMD_COUNT_TGT, pick_pixel(0, l - 1));
          2: send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
          default: send_item(hme_pkg::CMD_MAP, pick_pixel(0, l - 1));
        endcase
        sent++;
      end
      sent++;
      if ($urandom_range(0, 9) == 0) begin
        send_item(hme_pkg::CMD_CLEAR, 8'd0);
        send_item(hme_pkg::CMD_MAP, 8'($urandom_range(0, 255)));
        sent += 2;
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(hme_pkg::CMD_CLEAR, 8'd0);
    send_item(hme_pkg::CMD_MAP, 8'd7);
    send_item(hme_pkg::CMD_BUILD, 8'd0);
    send_item(hme_pkg::CMD_COUNT_SRC, 8'd0);
    send_item(hme_pkg::CMD_BUILD, 8'd0);
    send_item(hme_pkg::CMD_COUNT_SRC, 8'd255);
    send_item(hme_pkg::CMD_COUNT_SRC, 8'd128);
    send_item(hme_pkg::CMD_COUNT_TGT, 8'd0);
    send_item(hme_pkg::CMD_COUNT_TGT, 8'd255);
    send_item(hme_pkg::CMD_COUNT_TGT, 8'd85);
    send_item(hme_pkg::CMD_BUILD, 8'd0);
    send_item(hme_pkg::CMD_MAP, 8'd0);
    send_item(hme_pkg::CMD_MAP, 8'd255);
    send_item(hme_pkg::CMD_MAP, 8'd128);
    send_item(3'd5, 8'd1);
    send_item(3'd6, 8'd170);
    send_item(3'd7, 8'd255);
    send_item(hme_pkg::CMD_COUNT_TGT, 8'd3);
    send_item(hme_pkg::CMD_MAP, 8'd1);
    send_item(hme_pkg::CMD_CLEAR, 8'd0);
    send_item(hme_pkg::CMD_MAP, 8'd128);

    run_phase(2, 220);
    run_phase($urandom_range(3, 255), 240);
    run_phase(0, 160);
    run_phase(1, 160);
    run_phase(511, 220);
    run_phase(300, 200);
    run_phase($urandom_range(3, 64), 240);
    run_phase(256, 240);
    idle_on = 1'b0;
    run_phase($urandom_range(2, 256), 250);

    settle();
    if (tracker.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
